[design/zoom_crop_window_control_assert.svh]
// Assertion macros for the zoom crop window control checker
`ifndef ZOOM_CROP_WINDOW_CONTROL_ASSERT_SVH
`define ZOOM_CROP_WINDOW_CONTROL_ASSERT_SVH
// implication checked every clock outside reset
`define ZCW_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("%m: implication failed");
// next-cycle implication checked outside reset
`define ZCW_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("%m: next-cycle implication failed");
`endif

[design/zcw_pkg.sv]
// Shared types and constants for the zoom crop window control
package zcw_pkg;
    localparam int COORD_W = 13;
    localparam logic [COORD_W-1:0] COORD_MAX = 13'd4096;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_STOP  = 2'd1,
        KIND_MOVE  = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        REG_WINDOW_X       = 3'd0,
        REG_WINDOW_Y       = 3'd1,
        REG_WINDOW_WIDTH   = 3'd2,
        REG_WINDOW_HEIGHT  = 3'd3,
        REG_PICTURE_WIDTH  = 3'd4,
        REG_PICTURE_HEIGHT = 3'd5
    } reg_index_t;

    // scaling jobs run one after another through the shared divider
    typedef enum logic [1:0] {
        JOB_X = 2'd0,
        JOB_Y = 2'd1,
        JOB_W = 2'd2,
        JOB_H = 2'd3
    } job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_DIV,
        ST_STORE,
        ST_WRITE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic  load;
        logic  mul;
        logic  div_start;
        logic  store;
        logic  write;
        logic  emit;
        job_t  job;
    } cmd_t;

    typedef struct packed {
        logic  div_done;
        kind_t kind;
    } stat_t;
endpackage

[design/zcw_ram.sv]
// Generic RAM with one write port and one read port, registered read
module zcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[design/zcw_div.sv]
// Restoring divider, one quotient bit per cycle
module zcw_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [25:0] dividend,
    input  logic [12:0] divisor,
    output logic        done,
    output logic [25:0] quotient
);
    logic [25:0] quo_reg, quo_next;
    logic [13:0] rem_reg, rem_next;
    logic [12:0] den_reg, den_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [14:0] trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[25]} - {2'b00, den_reg};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = (divisor == '0) ? 13'd1 : divisor;
            cnt_next  = 5'd25;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[14])
            begin
                rem_next = trial[13:0];
                quo_next = {quo_reg[24:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[12:0], quo_reg[25]};
                quo_next = {quo_reg[24:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

[design/zcw_ctrl.sv]
// Sequencer for the zoom crop window control
module zcw_ctrl
    import zcw_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    output logic  busy,
    output cmd_t  cmd,
    input  stat_t stat
);
    state_t state_reg, state_next;
    job_t   job_reg, job_next;

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_LOAD;
                    job_next   = JOB_X;
                end
            end
            ST_LOAD:
            begin
                if (stat.kind == KIND_START || stat.kind == KIND_MOVE)
                begin
                    state_next = ST_MUL;
                end
                else
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_MUL:   state_next = ST_DIV;
            ST_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                if ((stat.kind == KIND_START && job_reg == JOB_H) ||
                    (stat.kind == KIND_MOVE && job_reg == JOB_Y))
                begin
                    state_next = ST_WRITE;
                end
                else
                begin
                    job_next   = job_t'(job_reg + 2'd1);
                    state_next = ST_MUL;
                end
            end
            ST_WRITE: state_next = ST_DONE;
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.job       = job_reg;
        cmd.load      = (state_reg == ST_LOAD);
        cmd.mul       = (state_reg == ST_MUL);
        cmd.div_start = (state_reg == ST_MUL);
        cmd.store     = (state_reg == ST_STORE);
        cmd.write     = (state_reg == ST_WRITE);
        cmd.emit      = (state_reg == ST_DONE);
        busy          = (state_reg != ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            job_reg   <= JOB_X;
        end
        else
        begin
            state_reg <= state_next;
            job_reg   <= job_next;
        end
    end
endmodule

[design/zcw_dp.sv]
// Datapath: configuration, per-channel stores, scaling and panning
module zcw_dp
    import zcw_pkg::*;
#(
    parameter int CHANNELS = 16,
    parameter int MIN_CROP = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  kind,
    input  logic [3:0]  channel,
    input  logic        full_view,
    input  logic [11:0] pos_x,
    input  logic [11:0] pos_y,
    input  logic [12:0] far_x,
    input  logic [12:0] far_y,
    input  logic        cfg_valid,
    input  logic [2:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  cmd_t        cmd,
    output stat_t       stat,
    output logic        done,
    output logic [3:0]  out_channel,
    output logic        crop_on,
    output logic [12:0] crop_left,
    output logic [12:0] crop_top,
    output logic [12:0] crop_width,
    output logic [12:0] crop_height,
    output logic        status
);
    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ROW_W = 4 * COORD_W;

    logic [11:0] win_x_reg, win_y_reg;
    logic [12:0] win_w_reg, win_h_reg, pic_w_reg, pic_h_reg;

    kind_t       kind_reg;
    logic [CH_W-1:0] ch_reg;
    logic [11:0] px_reg, py_reg;
    logic [12:0] fx_reg, fy_reg;
    logic [12:0] res_reg [4];
    logic [12:0] left_reg, top_reg, wid_reg, hgt_reg;
    logic        status_reg;
    logic [25:0] prod;
    logic [12:0] den_sel;
    logic        neg_reg, act_reg;

    logic [CHANNELS-1:0] en_reg;
    logic [CHANNELS-1:0] valid_reg;
    logic [ROW_W-1:0]    row_rd, row_wd;
    logic                ram_we;

    logic [CH_W-1:0] ch_sel;
    logic [CH_W-1:0] wrap_tab [16];
    logic [3:0]      ch_raw;
    logic            div_done;
    logic [25:0]     quo;
    logic [12:0]     sat_q;
    logic [13:0]     mag;
    logic [12:0]     num_sel, val_sel;

    // wrapped channel for every raw index, fixed at elaboration
    for (genvar g = 0; g < 16; g++)
    begin : g_wrap
        assign wrap_tab[g] = CH_W'(g % CHANNELS);
    end

    // channel index wraps; full_view forces channel zero
    always_comb
    begin
        ch_raw = full_view ? 4'd0 : channel;
        ch_sel = wrap_tab[ch_raw];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_x_reg <= '0;
            win_y_reg <= '0;
            win_w_reg <= 13'd1920;
            win_h_reg <= 13'd1080;
            pic_w_reg <= 13'd1920;
            pic_h_reg <= 13'd1080;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_WINDOW_X:       win_x_reg <= cfg_data[11:0];
                REG_WINDOW_Y:       win_y_reg <= cfg_data[11:0];
                REG_WINDOW_WIDTH:   win_w_reg <= cfg_data;
                REG_WINDOW_HEIGHT:  win_h_reg <= cfg_data;
                REG_PICTURE_WIDTH:  pic_w_reg <= cfg_data;
                REG_PICTURE_HEIGHT: pic_h_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            kind_reg <= kind_t'(kind);
            ch_reg   <= ch_sel;
            px_reg   <= pos_x;
            py_reg   <= pos_y;
            fx_reg   <= far_x;
            fy_reg   <= far_y;
        end
    end

    zcw_ram #(.WIDTH(ROW_W), .DEPTH(CHANNELS)) u_rect_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ch_reg),
        .wdata (row_wd),
        .raddr ((start && !busy) ? ch_sel : ch_reg),
        .rdata (row_rd)
    );

    // a row never written reads as zero; write-back updates the shown row
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            if (valid_reg[ch_reg])
            begin
                {left_reg, top_reg, wid_reg, hgt_reg} <= row_rd;
            end
            else
            begin
                {left_reg, top_reg, wid_reg, hgt_reg} <= '0;
            end
        end
        else if (cmd.write && ram_we)
        begin
            {left_reg, top_reg, wid_reg, hgt_reg} <= row_wd;
        end
    end

    // operand select for the current scaling job
    always_comb
    begin
        mag     = '0;
        num_sel = pic_w_reg;
        val_sel = '0;
        case (cmd.job)
            JOB_X:
            begin
                num_sel = pic_w_reg;
                if (kind_reg == KIND_MOVE)
                begin
                    mag = ({1'b0, fx_reg} >= {2'b00, px_reg}) ?
                          {1'b0, fx_reg} - {2'b00, px_reg} :
                          {2'b00, px_reg} - {1'b0, fx_reg};
                    val_sel = mag[12:0];
                end
                else
                begin
                    val_sel = (px_reg > win_x_reg) ? {1'b0, px_reg - win_x_reg} : '0;
                end
            end
            JOB_Y:
            begin
                num_sel = pic_h_reg;
                if (kind_reg == KIND_MOVE)
                begin
                    mag = ({1'b0, fy_reg} >= {2'b00, py_reg}) ?
                          {1'b0, fy_reg} - {2'b00, py_reg} :
                          {2'b00, py_reg} - {1'b0, fy_reg};
                    val_sel = mag[12:0];
                end
                else
                begin
                    val_sel = (py_reg > win_y_reg) ? {1'b0, py_reg - win_y_reg} : '0;
                end
            end
            JOB_W:
            begin
                num_sel = pic_w_reg;
                val_sel = fx_reg;
            end
            JOB_H:
            begin
                num_sel = pic_h_reg;
                val_sel = fy_reg;
            end
            default: ;
        endcase
    end

    // product and divisor are taken by the divider as it starts
    always_comb
    begin
        prod    = {13'd0, val_sel} * {13'd0, num_sel};
        den_sel = (cmd.job == JOB_X || cmd.job == JOB_W) ? win_w_reg : win_h_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            if (cmd.job == JOB_X)
            begin
                neg_reg <= {1'b0, fx_reg} < {2'b00, px_reg};
                act_reg <= mag >= 14'd4;
            end
            else
            begin
                neg_reg <= {1'b0, fy_reg} < {2'b00, py_reg};
                act_reg <= mag >= 14'd4;
            end
        end
    end

    zcw_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod),
        .divisor  (den_sel),
        .done     (div_done),
        .quotient (quo)
    );

    assign sat_q = (quo > 26'(COORD_MAX)) ? COORD_MAX : quo[12:0];

    // pan one axis opposite to the drag
    function automatic logic [12:0] pan_axis(
        input logic [12:0] origin,
        input logic [12:0] size,
        input logic [25:0] q,
        input logic [12:0] pic,
        input logic        neg,
        input logic        act
    );
        logic [26:0] stp;
        logic [27:0] pos;
        logic [12:0] res;
        stp = ({1'b0, q} + 27'd3) & ~27'd3;
        res = origin;
        if (act && !neg)
        begin
            res = ({14'd0, origin} >= {1'b0, stp}) ? 13'({14'd0, origin} - {1'b0, stp}) : '0;
        end
        else if (act)
        begin
            pos = {15'd0, origin} + {1'b0, stp};
            if (pos + {15'd0, size} >= {15'd0, pic})
            begin
                pos = ({15'd0, pic} >= {15'd0, size}) ? {15'd0, pic} - {15'd0, size} : '0;
            end
            res = (pos > 28'(COORD_MAX)) ? COORD_MAX : pos[12:0];
        end
        return res;
    endfunction

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            if (kind_reg == KIND_MOVE)
            begin
                if (cmd.job == JOB_X)
                begin
                    res_reg[0] <= pan_axis(left_reg, wid_reg, quo, pic_w_reg, neg_reg, act_reg);
                end
                else
                begin
                    res_reg[1] <= pan_axis(top_reg, hgt_reg, quo, pic_h_reg, neg_reg, act_reg);
                end
            end
            else
            begin
                case (cmd.job)
                    JOB_X:   res_reg[0] <= sat_q & ~13'd3;
                    JOB_Y:   res_reg[1] <= sat_q & ~13'd3;
                    JOB_W:   res_reg[2] <= sat_q & ~13'd7;
                    default: res_reg[3] <= sat_q & ~13'd7;
                endcase
            end
        end
    end

    // write-back of the row, and the result registers
    always_comb
    begin
        ram_we = 1'b0;
        row_wd = {left_reg, top_reg, wid_reg, hgt_reg};
        if (cmd.write)
        begin
            case (kind_reg)
                KIND_START:
                begin
                    ram_we = (res_reg[2] >= 13'(MIN_CROP)) && (res_reg[3] >= 13'(MIN_CROP));
                    row_wd = {res_reg[0], res_reg[1], res_reg[2], res_reg[3]};
                end
                KIND_STOP:
                begin
                    ram_we = 1'b1;
                    row_wd = '0;
                end
                KIND_MOVE:
                begin
                    ram_we = 1'b1;
                    row_wd = {res_reg[0], res_reg[1], wid_reg, hgt_reg};
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg    <= '0;
            valid_reg <= '0;
        end
        else if (ram_we)
        begin
            valid_reg[ch_reg] <= 1'b1;
            en_reg[ch_reg]    <= (kind_reg == KIND_STOP) ? 1'b0 :
                                 (kind_reg == KIND_START) ? 1'b1 : en_reg[ch_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            status_reg <= (kind_reg == KIND_START) && !ram_we;
        end
    end

    assign stat          = {div_done, kind_reg};
    assign done          = cmd.emit;
    assign out_channel   = 4'(ch_reg);
    assign crop_on       = en_reg[ch_reg];
    assign crop_left     = left_reg;
    assign crop_top      = top_reg;
    assign crop_width    = wid_reg;
    assign crop_height   = hgt_reg;
    assign status        = status_reg;
endmodule

[design/zoom_crop_window_control.sv]
// Top level: zoom crop window control
// Sequence: stop or unused items pass LOAD, WRITE, DONE (done high); start and move
// items pass MUL, DIV, STORE per scaled value in between; the next item is taken from
// the cycle after done. One item at a time; a scaled value takes operands, the 26-step
// shared divider until its done, then store; four values for start, two for move.
// Reset: asynchronous active low; configuration registers to defaults, all channels cropping off.
module zoom_crop_window_control
    import zcw_pkg::*;
#(
    parameter int CHANNELS = 16,
    parameter int MIN_CROP = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  kind,
    input  logic [3:0]  channel,
    input  logic        full_view,
    input  logic [11:0] pos_x,
    input  logic [11:0] pos_y,
    input  logic [12:0] far_x,
    input  logic [12:0] far_y,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [12:0] cfg_data,
    output logic        done,
    output logic [3:0]  out_channel,
    output logic        crop_on,
    output logic [12:0] crop_left,
    output logic [12:0] crop_top,
    output logic [12:0] crop_width,
    output logic [12:0] crop_height,
    output logic        status
);
    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    zcw_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    zcw_dp #(.CHANNELS(CHANNELS), .MIN_CROP(MIN_CROP)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .channel     (channel),
        .full_view   (full_view),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .far_x       (far_x),
        .far_y       (far_y),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .stat        (stat),
        .done        (done),
        .out_channel (out_channel),
        .crop_on     (crop_on),
        .crop_left   (crop_left),
        .crop_top    (crop_top),
        .crop_width  (crop_width),
        .crop_height (crop_height),
        .status      (status)
    );
endmodule

[design/zcw_checker.sv]
// Port-level checker for the zoom crop window control, with its bind
`include "zoom_crop_window_control_assert.svh"
module zcw_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic        crop_on,
    input logic [12:0] crop_width
);
    `ZCW_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
    `ZCW_ASSERT_IMP(a_done_busy, clk, rst_n, done, busy)
    `ZCW_ASSERT_NEXT(a_done_idle, clk, rst_n, done, !busy)
    `ZCW_ASSERT_IMP(a_on_width, clk, rst_n, done && crop_on, crop_width != 13'd0)
endmodule

bind zoom_crop_window_control zcw_checker u_zcw_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .crop_on    (crop_on),
    .crop_width (crop_width)
);
